[rtl/core/ear_pkg.sv]
`default_nettype none

package ear_pkg;

	localparam int RATIO_BITS     = 12;
	localparam int RUN_BITS       = 16;
	localparam int FRAC_BITS      = 10;
	localparam int Q4_SHIFT       = 8;
	localparam int DIV_STEPS      = 12;
	localparam int DIV_CNT_BITS   = 4;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};
	localparam logic [RUN_BITS-1:0]   RUN_MAX   = {RUN_BITS{1'b1}};

	localparam logic [RATIO_BITS-1:0] THRESHOLD_RESET = 12'd235;
	localparam logic [RUN_BITS-1:0]   RUN_LIMIT_RESET = 16'd150;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CLOSED_THRESHOLD = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_LIMIT        = 1'b1;

	typedef struct packed {
		logic [RATIO_BITS-1:0] aspect_ratio;
		logic                  eye_closed;
		logic                  drowsy;
		logic [RUN_BITS-1:0]   closed_run;
		logic                  degenerate;
	} result_t;

endpackage

`default_nettype wire

[rtl/core/ear_in_if.sv]
`default_nettype none

interface ear_in_if #(
	parameter int COORD_BITS = 12
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] corner_a_x;
	logic [COORD_BITS-1:0] corner_a_y;
	logic [COORD_BITS-1:0] upper_a_x;
	logic [COORD_BITS-1:0] upper_a_y;
	logic [COORD_BITS-1:0] upper_b_x;
	logic [COORD_BITS-1:0] upper_b_y;
	logic [COORD_BITS-1:0] corner_b_x;
	logic [COORD_BITS-1:0] corner_b_y;
	logic [COORD_BITS-1:0] lower_b_x;
	logic [COORD_BITS-1:0] lower_b_y;
	logic [COORD_BITS-1:0] lower_a_x;
	logic [COORD_BITS-1:0] lower_a_y;

	modport source (
		output valid, corner_a_x, corner_a_y, upper_a_x, upper_a_y, upper_b_x, upper_b_y,
		       corner_b_x, corner_b_y, lower_b_x, lower_b_y, lower_a_x, lower_a_y,
		input  ready
	);
	modport sink (
		input  valid, corner_a_x, corner_a_y, upper_a_x, upper_a_y, upper_b_x, upper_b_y,
		       corner_b_x, corner_b_y, lower_b_x, lower_b_y, lower_a_x, lower_a_y,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/ear_out_if.sv]
`default_nettype none

interface ear_out_if ();
	logic                             valid;
	logic                             ready;
	logic [ear_pkg::RATIO_BITS-1:0]   aspect_ratio;
	logic                             eye_closed;
	logic                             drowsy;
	logic [ear_pkg::RUN_BITS-1:0]     closed_run;
	logic                             degenerate;

	modport source (
		output valid, aspect_ratio, eye_closed, drowsy, closed_run, degenerate,
		input  ready
	);
	modport sink (
		input  valid, aspect_ratio, eye_closed, drowsy, closed_run, degenerate,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/ear_isqrt.sv]
`default_nettype none

// Radix-4 digit-by-digit square root, one root bit per cycle.
module ear_isqrt #(
	parameter int ROOT_BITS = 17
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [2*ROOT_BITS-1:0] radicand,
	output logic      [ROOT_BITS-1:0]   root,
	output logic                        done
);
	localparam int RAD_BITS = 2 * ROOT_BITS;
	localparam int REM_BITS = ROOT_BITS + 2;
	localparam int CNT_BITS = $clog2(ROOT_BITS);

	logic [RAD_BITS-1:0]  rad_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [REM_BITS+1:0] rem_sh;
	logic [REM_BITS+1:0] trial;
	logic [REM_BITS+1:0] diff;
	logic                ge;

	assign rem_sh = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign diff   = rem_sh - trial;
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_BITS'(ROOT_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
			root_q <= {root_q[ROOT_BITS-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

`default_nettype wire

[rtl/core/eye_aspect_ratio_drowsiness_unit.sv]
`default_nettype none

// Channel     Direction  Content
// landmarks   in         six eye landmarks of one frame, COORD_BITS per coordinate
// status      out        aspect ratio, closed and drowsy flags, closed run, degenerate flag
// wr_*        in         configuration writes: closed threshold, run limit
//
// An item runs the bit-serial square root three times, then the 12-step restoring divider.
// A single squarer is shared by all six coordinate differences.
// Reset clears the closed run and restores the threshold to 235 and the limit to 150.
// The next item is taken as soon as the previous result sits in the output register;
// a result waits in the last state only while that register is full and not being read.
module eye_aspect_ratio_drowsiness_unit #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [ear_pkg::CFG_INDEX_BITS-1:0]  wr_index,
	input  wire logic [ear_pkg::CFG_DATA_BITS-1:0]   wr_data,
	ear_in_if.sink                                   landmarks,
	ear_out_if.source                                status
);
	localparam int ROOT_BITS = COORD_BITS + 5;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int NUM_BITS  = ROOT_BITS + 1 + ear_pkg::FRAC_BITS;
	localparam int DSH_BITS  = ROOT_BITS + ear_pkg::DIV_STEPS;
	localparam int CHK_BITS  = ROOT_BITS + 1 + ear_pkg::DIV_STEPS;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SQX    = 3'd1;
	localparam logic [2:0] S_SQY    = 3'd2;
	localparam logic [2:0] S_ROOT   = 3'd3;
	localparam logic [2:0] S_DIVCHK = 3'd4;
	localparam logic [2:0] S_DIV    = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	localparam logic [1:0] DIST_V1 = 2'd0;
	localparam logic [1:0] DIST_V2 = 2'd1;
	localparam logic [1:0] DIST_H  = 2'd2;

	logic [2:0] state_q;
	logic [1:0] dist_q;
	logic [ear_pkg::DIV_CNT_BITS-1:0] cnt_q;

	logic [ear_pkg::RATIO_BITS-1:0] thr_q;
	logic [ear_pkg::RUN_BITS-1:0]   lim_q;
	logic [ear_pkg::RUN_BITS-1:0]   run_q;

	logic [COORD_BITS-1:0] ca_x_q, ca_y_q, ua_x_q, ua_y_q, ub_x_q, ub_y_q;
	logic [COORD_BITS-1:0] cb_x_q, cb_y_q, lb_x_q, lb_y_q, la_x_q, la_y_q;

	logic [2*COORD_BITS-1:0] sq_q;
	logic [ROOT_BITS-1:0]    v1_q, v2_q, h_q;
	logic [NUM_BITS-1:0]     rem_q;
	logic [DSH_BITS-1:0]     dsh_q;
	logic [ear_pkg::RATIO_BITS-1:0] quo_q;
	logic                    sat_q;

	logic             out_valid_q;
	ear_pkg::result_t out_q;

	logic [COORD_BITS-1:0]   p0x, p0y, p1x, p1y, dx, dy, mop;
	logic [2*COORD_BITS-1:0] prod;
	logic [2*COORD_BITS:0]   sq_sum;
	logic                    root_start;
	logic [RAD_BITS-1:0]     radicand;
	logic [ROOT_BITS-1:0]    root;
	logic                    root_done;

	logic                           div_ge;
	logic [DSH_BITS-1:0]            div_diff;
	logic [ear_pkg::RATIO_BITS-1:0] ratio;
	logic                           closed;
	logic [ear_pkg::RUN_BITS-1:0]   run_next;
	logic                           load_out;
	logic                           accept;

	assign accept = landmarks.valid && landmarks.ready;
	assign landmarks.ready = (state_q == S_IDLE);

	always_comb begin
		case (dist_q)
			DIST_V1: begin
				p0x = ua_x_q; p0y = ua_y_q; p1x = la_x_q; p1y = la_y_q;
			end
			DIST_V2: begin
				p0x = ub_x_q; p0y = ub_y_q; p1x = lb_x_q; p1y = lb_y_q;
			end
			default: begin
				p0x = ca_x_q; p0y = ca_y_q; p1x = cb_x_q; p1y = cb_y_q;
			end
		endcase
	end

	assign dx     = (p0x > p1x) ? (p0x - p1x) : (p1x - p0x);
	assign dy     = (p0y > p1y) ? (p0y - p1y) : (p1y - p0y);
	assign mop    = (state_q == S_SQX) ? dx : dy;
	assign prod   = mop * mop;
	assign sq_sum = {1'b0, sq_q} + {1'b0, prod};

	assign root_start = (state_q == S_SQY);
	assign radicand   = RAD_BITS'({sq_sum, {ear_pkg::Q4_SHIFT{1'b0}}});

	ear_isqrt #(
		.ROOT_BITS(ROOT_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand),
		.root     (root),
		.done     (root_done)
	);

	assign div_ge   = ({1'b0, rem_q} >= dsh_q);
	assign div_diff = {1'b0, rem_q} - dsh_q;

	assign ratio    = sat_q ? ear_pkg::RATIO_MAX : quo_q;
	assign closed   = (ratio < thr_q);
	assign run_next = !closed ? '0 :
	                  (run_q == ear_pkg::RUN_MAX) ? run_q : (run_q + 1'b1);
	assign load_out = (state_q == S_OUT) && (!out_valid_q || status.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dist_q      <= DIST_V1;
			cnt_q       <= '0;
			thr_q       <= ear_pkg::THRESHOLD_RESET;
			lim_q       <= ear_pkg::RUN_LIMIT_RESET;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					ear_pkg::REG_CLOSED_THRESHOLD: thr_q <= wr_data[ear_pkg::RATIO_BITS-1:0];
					ear_pkg::REG_RUN_LIMIT:        lim_q <= wr_data[ear_pkg::RUN_BITS-1:0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
				run_q       <= run_next;
			end else if (status.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						dist_q  <= DIST_V1;
						state_q <= S_SQX;
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_ROOT;
				S_ROOT: begin
					if (root_done) begin
						if (dist_q == DIST_H) begin
							state_q <= S_DIVCHK;
						end else begin
							dist_q  <= dist_q + 1'b1;
							state_q <= S_SQX;
						end
					end
				end
				S_DIVCHK: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ear_pkg::DIV_CNT_BITS'(ear_pkg::DIV_STEPS - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ca_x_q <= landmarks.corner_a_x;
			ca_y_q <= landmarks.corner_a_y;
			ua_x_q <= landmarks.upper_a_x;
			ua_y_q <= landmarks.upper_a_y;
			ub_x_q <= landmarks.upper_b_x;
			ub_y_q <= landmarks.upper_b_y;
			cb_x_q <= landmarks.corner_b_x;
			cb_y_q <= landmarks.corner_b_y;
			lb_x_q <= landmarks.lower_b_x;
			lb_y_q <= landmarks.lower_b_y;
			la_x_q <= landmarks.lower_a_x;
			la_y_q <= landmarks.lower_a_y;
		end

		if (state_q == S_SQX) begin
			sq_q <= prod;
		end

		if (state_q == S_ROOT && root_done) begin
			case (dist_q)
				DIST_V1: v1_q <= root;
				DIST_V2: v2_q <= root;
				default: h_q  <= root;
			endcase
		end

		// The quotient fits in twelve bits exactly when the numerator is below
		// the divisor scaled by 4096; a zero divisor always saturates.
		if (state_q == S_DIVCHK) begin
			rem_q <= {({1'b0, v1_q} + {1'b0, v2_q}), {ear_pkg::FRAC_BITS{1'b0}}};
			dsh_q <= {h_q, 1'b0, {(ear_pkg::DIV_STEPS - 1){1'b0}}};
			sat_q <= (CHK_BITS'({({1'b0, v1_q} + {1'b0, v2_q}), {ear_pkg::FRAC_BITS{1'b0}}})
			          >= {h_q, 1'b0, {ear_pkg::DIV_STEPS{1'b0}}});
			quo_q <= '0;
		end else if (state_q == S_DIV) begin
			if (div_ge) begin
				rem_q <= div_diff[NUM_BITS-1:0];
			end
			dsh_q <= {1'b0, dsh_q[DSH_BITS-1:1]};
			quo_q <= {quo_q[ear_pkg::RATIO_BITS-2:0], div_ge};
		end

		if (load_out) begin
			out_q.aspect_ratio <= ratio;
			out_q.eye_closed   <= closed;
			out_q.drowsy       <= closed && (run_next >= lim_q);
			out_q.closed_run   <= run_next;
			out_q.degenerate   <= (h_q == '0);
		end
	end

	assign status.valid        = out_valid_q;
	assign status.aspect_ratio = out_q.aspect_ratio;
	assign status.eye_closed   = out_q.eye_closed;
	assign status.drowsy       = out_q.drowsy;
	assign status.closed_run   = out_q.closed_run;
	assign status.degenerate   = out_q.degenerate;
endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int COORD_BITS  = 12;
	localparam int ITEM_CYCLES = 3 * (COORD_BITS + 8) + 15;
	localparam int IDLE_PCT    = 30;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [ear_pkg::RATIO_BITS-1:0] ratio_t;
	typedef logic [ear_pkg::RUN_BITS-1:0] run_t;

	typedef struct packed {
		coord_t corner_a_x;
		coord_t corner_a_y;
		coord_t upper_a_x;
		coord_t upper_a_y;
		coord_t upper_b_x;
		coord_t upper_b_y;
		coord_t corner_b_x;
		coord_t corner_b_y;
		coord_t lower_b_x;
		coord_t lower_b_y;
		coord_t lower_a_x;
		coord_t lower_a_y;
	} frame_t;

	typedef struct {
		frame_t           marks;
		ratio_t           thr;
		run_t             lim;
		bit               pinned;
		ear_pkg::result_t want;
	} probe_row_t;

	typedef enum {EYE_CLOSED, EYE_OPEN, EYE_NEAR, EYE_DEGENERATE, EYE_NOISE} eye_shape_t;

	logic                               clk;
	logic                               arst_n;
	logic                               wr_en;
	logic [ear_pkg::CFG_INDEX_BITS-1:0] wr_index;
	logic [ear_pkg::CFG_DATA_BITS-1:0]  wr_data;

	ear_in_if #(.COORD_BITS(COORD_BITS)) landmarks_if ();
	ear_out_if status_if ();

	eye_aspect_ratio_drowsiness_unit #(
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.landmarks (landmarks_if),
		.status    (status_if)
	);

	ratio_t closed_thr;
	run_t   run_lim;
	run_t   closed_count;

	ear_pkg::result_t status_expect_q[$];
	probe_row_t       pinned_q[$];
	probe_row_t       probe_rows[$];

	int  failures;
	int  reports;
	int  items_sent;
	int  cycle_count;
	int  hold_requests;
	bit  stall_on;
	bit  idle_on;

	always #1 clk = ~clk;

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			b = r | (64'd1 << i);
			if (b * b <= v) r = b;
		end
		return r;
	endfunction

	function automatic longint unsigned span_q4(input coord_t ax, input coord_t ay,
	                                           input coord_t bx, input coord_t by);
		longint unsigned dx;
		longint unsigned dy;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		return root_floor((dx * dx + dy * dy) << ear_pkg::Q4_SHIFT);
	endfunction

	function automatic ear_pkg::result_t predict_status(input frame_t f);
		longint unsigned v1;
		longint unsigned v2;
		longint unsigned h;
		longint unsigned quot;
		ear_pkg::result_t r;
		v1 = span_q4(f.upper_a_x, f.upper_a_y, f.lower_a_x, f.lower_a_y);
		v2 = span_q4(f.upper_b_x, f.upper_b_y, f.lower_b_x, f.lower_b_y);
		h  = span_q4(f.corner_a_x, f.corner_a_y, f.corner_b_x, f.corner_b_y);
		r.degenerate = (h == 0);
		if (h == 0) begin
			quot = ear_pkg::RATIO_MAX;
		end else begin
			quot = ((v1 + v2) << ear_pkg::FRAC_BITS) / (2 * h);
			if (quot > ear_pkg::RATIO_MAX) quot = ear_pkg::RATIO_MAX;
		end
		r.aspect_ratio = quot[ear_pkg::RATIO_BITS-1:0];
		r.eye_closed = (quot < closed_thr);
		r.drowsy = 1'b0;
		if (r.eye_closed) begin
			if (closed_count != ear_pkg::RUN_MAX) closed_count = closed_count + 1'b1;
			r.drowsy = (closed_count >= run_lim);
		end else begin
			closed_count = '0;
		end
		r.closed_run = closed_count;
		return r;
	endfunction

	function automatic frame_t points(input int cax, input int cay, input int uax, input int uay,
	                                  input int ubx, input int uby, input int cbx, input int cby,
	                                  input int lbx, input int lby, input int lax, input int lay);
		frame_t f;
		f = '{coord_t'(cax), coord_t'(cay), coord_t'(uax), coord_t'(uay), coord_t'(ubx),
		      coord_t'(uby), coord_t'(cbx), coord_t'(cby), coord_t'(lbx), coord_t'(lby),
		      coord_t'(lax), coord_t'(lay)};
		return f;
	endfunction

	function automatic frame_t make_frame(input eye_shape_t shape);
		frame_t f;
		int span;
		int cax;
		int cay;
		int vert_a;
		int vert_b;
		int mx_a;
		int mx_b;
		if (shape == EYE_NOISE) begin
			for (int i = 0; i < 12; i++) f[i*COORD_BITS +: COORD_BITS] = coord_t'($urandom);
			return f;
		end
		span = ($urandom_range(4) == 0) ? $urandom_range(8, 64) : $urandom_range(8, 2000);
		cax = $urandom_range(0, 4093 - span);
		cay = $urandom_range(1024, 3071);
		case (shape)
			EYE_CLOSED: begin
				vert_a = $urandom_range(0, span / 8);
				vert_b = $urandom_range(0, span / 8);
			end
			EYE_OPEN: begin
				vert_a = $urandom_range(span / 4, span * 3 / 5);
				vert_b = $urandom_range(span / 4, span * 3 / 5);
			end
			EYE_NEAR: begin
				vert_a = (span * closed_thr) / 1024 + $urandom_range(0, 2) - 1;
				vert_b = (span * closed_thr) / 1024 + $urandom_range(0, 2) - 1;
			end
			default: begin
				vert_a = $urandom_range(0, 600);
				vert_b = $urandom_range(0, 600);
			end
		endcase
		if (vert_a < 0) vert_a = 0;
		if (vert_b < 0) vert_b = 0;
		if (vert_a > 1000) vert_a = 1000;
		if (vert_b > 1000) vert_b = 1000;
		mx_a = cax + span / 3;
		mx_b = cax + 2 * span / 3;
		f.corner_a_x = coord_t'(cax);
		f.corner_a_y = coord_t'(cay);
		if (shape == EYE_DEGENERATE) begin
			f.corner_b_x = coord_t'(cax);
			f.corner_b_y = coord_t'(cay);
		end else begin
			f.corner_b_x = coord_t'(cax + span);
			f.corner_b_y = coord_t'(cay + $urandom_range(0, 8));
		end
		f.upper_a_x = coord_t'(mx_a);
		f.upper_a_y = coord_t'(cay - vert_a / 2);
		f.lower_a_x = coord_t'(mx_a + $urandom_range(0, 1));
		f.lower_a_y = coord_t'(cay + vert_a - vert_a / 2);
		f.upper_b_x = coord_t'(mx_b);
		f.upper_b_y = coord_t'(cay - vert_b / 2);
		f.lower_b_x = coord_t'(mx_b + $urandom_range(0, 1));
		f.lower_b_y = coord_t'(cay + vert_b - vert_b / 2);
		return f;
	endfunction

	function automatic void add_row(input frame_t f, input int thr, input int lim,
	                                input bit pinned, input ear_pkg::result_t want);
		probe_row_t row;
		row = '{f, ratio_t'(thr), run_t'(lim), pinned, want};
		probe_rows.insert(probe_rows.size(), row);
	endfunction

	task automatic send_frame(input frame_t f);
		if (idle_on) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				landmarks_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		landmarks_if.valid      <= 1'b1;
		landmarks_if.corner_a_x <= f.corner_a_x;
		landmarks_if.corner_a_y <= f.corner_a_y;
		landmarks_if.upper_a_x  <= f.upper_a_x;
		landmarks_if.upper_a_y  <= f.upper_a_y;
		landmarks_if.upper_b_x  <= f.upper_b_x;
		landmarks_if.upper_b_y  <= f.upper_b_y;
		landmarks_if.corner_b_x <= f.corner_b_x;
		landmarks_if.corner_b_y <= f.corner_b_y;
		landmarks_if.lower_b_x  <= f.lower_b_x;
		landmarks_if.lower_b_y  <= f.lower_b_y;
		landmarks_if.lower_a_x  <= f.lower_a_x;
		landmarks_if.lower_a_y  <= f.lower_a_y;
		@(posedge clk);
		while (!landmarks_if.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic settle();
		landmarks_if.valid <= 1'b0;
		@(posedge clk);
		while (status_expect_q.size() != 0) @(posedge clk);
		repeat (2 * ITEM_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input ratio_t thr, input run_t lim);
		wr_en    <= 1'b1;
		wr_index <= ear_pkg::REG_CLOSED_THRESHOLD;
		wr_data  <= {4'($urandom), thr};
		@(posedge clk);
		wr_index <= ear_pkg::REG_RUN_LIMIT;
		wr_data  <= lim;
		@(posedge clk);
		wr_en <= 1'b0;
		closed_thr = thr;
		run_lim = lim;
	endtask

	task automatic send_blinks(input int items, input int run_max);
		int stop_at;
		int roll;
		eye_shape_t shape;
		stop_at = items_sent + items;
		while (items_sent < stop_at) begin
			repeat ($urandom_range(1, run_max)) begin
				roll = $urandom_range(99);
				shape = (roll < 8) ? EYE_NOISE : (roll < 14) ? EYE_NEAR :
				        (roll < 18) ? EYE_DEGENERATE : EYE_CLOSED;
				send_frame(make_frame(shape));
			end
			repeat ($urandom_range(1, 3))
				send_frame(make_frame(($urandom_range(3) == 0) ? EYE_NEAR : EYE_OPEN));
		end
	endtask

	always @(posedge clk) begin : landmark_monitor
		frame_t seen;
		ear_pkg::result_t want;
		probe_row_t row;
		if (arst_n && landmarks_if.valid && landmarks_if.ready) begin
			seen.corner_a_x = landmarks_if.corner_a_x;
			seen.corner_a_y = landmarks_if.corner_a_y;
			seen.upper_a_x  = landmarks_if.upper_a_x;
			seen.upper_a_y  = landmarks_if.upper_a_y;
			seen.upper_b_x  = landmarks_if.upper_b_x;
			seen.upper_b_y  = landmarks_if.upper_b_y;
			seen.corner_b_x = landmarks_if.corner_b_x;
			seen.corner_b_y = landmarks_if.corner_b_y;
			seen.lower_b_x  = landmarks_if.lower_b_x;
			seen.lower_b_y  = landmarks_if.lower_b_y;
			seen.lower_a_x  = landmarks_if.lower_a_x;
			seen.lower_a_y  = landmarks_if.lower_a_y;
			want = predict_status(seen);
			if (pinned_q.size() != 0) begin
				row = pinned_q.pop_front();
				if (row.pinned) want = row.want;
			end
			status_expect_q.insert(status_expect_q.size(), want);
		end
	end

	always @(posedge clk) begin : status_check
		ear_pkg::result_t got;
		ear_pkg::result_t want;
		if (arst_n && status_if.valid && status_if.ready) begin
			got = '{status_if.aspect_ratio, status_if.eye_closed, status_if.drowsy,
			        status_if.closed_run, status_if.degenerate};
			if (status_expect_q.size() == 0) begin
				failures++;
				if (reports < MAX_REPORTS)
					$display("unexpected item: ratio %0d closed %0b drowsy %0b run %0d degen %0b",
					         got.aspect_ratio, got.eye_closed, got.drowsy, got.closed_run,
					         got.degenerate);
				reports++;
			end else begin
				want = status_expect_q.pop_front();
				if (got.aspect_ratio !== want.aspect_ratio || got.eye_closed !== want.eye_closed ||
				    got.drowsy !== want.drowsy || got.closed_run !== want.closed_run ||
				    got.degenerate !== want.degenerate) begin
					failures++;
					if (reports < MAX_REPORTS)
						$display({"mismatch at cycle %0d: ratio %0d/%0d closed %0b/%0b ",
						          "drowsy %0b/%0b run %0d/%0d degen %0b/%0b (expected/actual)"},
						         cycle_count, want.aspect_ratio, got.aspect_ratio,
						         want.eye_closed, got.eye_closed, want.drowsy, got.drowsy,
						         want.closed_run, got.closed_run, want.degenerate,
						         got.degenerate);
					reports++;
				end
			end
		end
	end

	initial begin : sink_side
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		status_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				status_if.ready <= 1'b0;
			end else if (stall_on && $urandom_range(99) < IDLE_PCT) begin
				status_if.ready <= 1'b0;
			end else begin
				status_if.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		frame_t shut;
		frame_t wide;
		frame_t plain;
		ear_pkg::result_t degen;
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		landmarks_if.valid = 1'b0;
		landmarks_if.corner_a_x = '0;
		landmarks_if.corner_a_y = '0;
		landmarks_if.upper_a_x = '0;
		landmarks_if.upper_a_y = '0;
		landmarks_if.upper_b_x = '0;
		landmarks_if.upper_b_y = '0;
		landmarks_if.corner_b_x = '0;
		landmarks_if.corner_b_y = '0;
		landmarks_if.lower_b_x = '0;
		landmarks_if.lower_b_y = '0;
		landmarks_if.lower_a_x = '0;
		landmarks_if.lower_a_y = '0;
		closed_thr = ear_pkg::THRESHOLD_RESET;
		run_lim = ear_pkg::RUN_LIMIT_RESET;
		closed_count = '0;
		failures = 0;
		reports = 0;
		items_sent = 0;
		hold_requests = 0;
		stall_on = 1'b1;
		idle_on = 1'b1;

		// The lids touch, so the ratio is zero; the opposite frame saturates it.
		shut  = points(0, 0, 100, 100, 200, 100, 4095, 0, 200, 100, 100, 100);
		wide  = points(0, 0, 0, 0, 0, 4095, 1, 0, 4095, 0, 4095, 4095);
		plain = points(100, 200, 115, 188, 145, 187, 160, 200, 145, 213, 115, 212);
		degen = '{ear_pkg::RATIO_MAX, 1'b0, 1'b0, 16'd0, 1'b1};

		add_row(points(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 235, 150, 1, degen);
		add_row(points(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095),
		        235, 150, 1, degen);
		add_row(shut, 235, 150, 1, '{12'd0, 1'b1, 1'b0, 16'd1, 1'b0});
		add_row(shut, 235, 150, 1, '{12'd0, 1'b1, 1'b0, 16'd2, 1'b0});
		add_row(wide, 235, 150, 1, '{ear_pkg::RATIO_MAX, 1'b0, 1'b0, 16'd0, 1'b0});
		add_row(plain, 235, 150, 0, '0);
		add_row(points(1000, 2000, 1020, 1993, 1040, 1993, 1060, 2000, 1040, 2006, 1020, 2006),
		        235, 150, 0, '0);
		add_row(points(1000, 2000, 1020, 1993, 1040, 1993, 1060, 2000, 1040, 2007, 1020, 2007),
		        235, 150, 0, '0);
		add_row(points(3000, 10, 4000, 17, 1234, 3210, 3137, 4000, 2345, 123, 5, 4090),
		        235, 150, 0, '0);
		add_row(points(500, 500, 480, 490, 520, 488, 500, 500, 520, 511, 480, 510),
		        235, 150, 1, degen);
		add_row(points(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 4095, 0, 1, degen);
		add_row(shut, 4095, 0, 1, '{12'd0, 1'b1, 1'b1, 16'd1, 1'b0});
		add_row(shut, 4095, 0, 1, '{12'd0, 1'b1, 1'b1, 16'd2, 1'b0});
		add_row(wide, 4095, 0, 1, '{ear_pkg::RATIO_MAX, 1'b0, 1'b0, 16'd0, 1'b0});
		add_row(shut, 4095, 0, 1, '{12'd0, 1'b1, 1'b1, 16'd1, 1'b0});
		add_row(shut, 0, 65535, 1, '{12'd0, 1'b0, 1'b0, 16'd0, 1'b0});
		add_row(plain, 0, 65535, 0, '0);
		add_row(shut, 4095, 3, 1, '{12'd0, 1'b1, 1'b0, 16'd1, 1'b0});
		add_row(shut, 4095, 3, 1, '{12'd0, 1'b1, 1'b0, 16'd2, 1'b0});
		add_row(shut, 4095, 3, 1, '{12'd0, 1'b1, 1'b1, 16'd3, 1'b0});
		add_row(shut, 4095, 3, 1, '{12'd0, 1'b1, 1'b1, 16'd4, 1'b0});
		add_row(wide, 4095, 3, 1, '{ear_pkg::RATIO_MAX, 1'b0, 1'b0, 16'd0, 1'b0});
		add_row(shut, 4095, 3, 1, '{12'd0, 1'b1, 1'b0, 16'd1, 1'b0});
		add_row(shut, 235, 1, 1, '{12'd0, 1'b1, 1'b1, 16'd2, 1'b0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_rows[i]) begin
			if (probe_rows[i].thr != closed_thr || probe_rows[i].lim != run_lim) begin
				settle();
				configure(probe_rows[i].thr, probe_rows[i].lim);
			end
			pinned_q.insert(pinned_q.size(), probe_rows[i]);
			send_frame(probe_rows[i].marks);
		end

		// A closure long enough to reach the default run limit.
		settle();
		configure(ear_pkg::THRESHOLD_RESET, ear_pkg::RUN_LIMIT_RESET);
		repeat (155) send_frame(make_frame(EYE_CLOSED));
		send_blinks(60, 12);

		// The receiver holds off while items keep coming, so the input backs up.
		settle();
		configure(ratio_t'($urandom_range(150, 400)), run_t'($urandom_range(1, 8)));
		hold_requests <= hold_requests + 1;
		send_blinks(150, 14);

		settle();
		idle_on = 1'b0;
		stall_on <= 1'b0;
		configure(ear_pkg::RATIO_MAX, 16'd1);
		send_blinks(100, 6);

		settle();
		idle_on = 1'b1;
		stall_on <= 1'b1;
		configure(ratio_t'($urandom_range(0, 4095)), run_t'($urandom_range(0, 12)));
		send_blinks(150, 16);

		settle();
		configure('0, ear_pkg::RUN_MAX);
		send_blinks(50, 8);

		settle();
		configure(ratio_t'($urandom_range(200, 300)), run_t'($urandom_range(1, 65535)));
		send_blinks(40, 10);

		settle();
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/ear_pkg.sv
rtl/core/ear_in_if.sv
rtl/core/ear_out_if.sv
rtl/core/ear_isqrt.sv
rtl/core/eye_aspect_ratio_drowsiness_unit.sv
verif/testbench.sv
